// File: rtl/core/imsf_pkg.sv
// Shared types and constants for the random-field Ising spin-flip block.
package imsf_pkg;

    localparam int SIDE_DEF = 64;
    localparam int RC_W     = 6;
    localparam int RND_W    = 16;
    localparam int FIELD_W  = 12;
    localparam int DE_W     = 15;
    localparam int CNT_W    = 32;
    localparam int THR_W    = 16;
    localparam int NTHR     = 18;
    localparam int THR_IW   = $clog2(NTHR);
    localparam int IN_W     = 32;
    localparam int OUT_W    = 88;
    localparam int APB_AW   = 6;
    localparam int APB_DW   = 64;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ATTEMPT = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [2:0] REG_FIELD      = 3'd0;
    localparam logic [2:0] REG_THR_0_3    = 3'd1;
    localparam logic [2:0] REG_THR_4_7    = 3'd2;
    localparam logic [2:0] REG_THR_8_11   = 3'd3;
    localparam logic [2:0] REG_THR_12_15  = 3'd4;
    localparam logic [2:0] REG_THR_16_17  = 3'd5;

    localparam logic [FIELD_W-1:0] FIELD_RESET = 12'd256;

    // Lattice fetch slots: the site, then its four neighbors
    localparam logic [2:0] NB_SITE = 3'd0;
    localparam logic [2:0] NB_UP   = 3'd1;
    localparam logic [2:0] NB_DN   = 3'd2;
    localparam logic [2:0] NB_LF   = 3'd3;
    localparam logic [2:0] NB_RT   = 3'd4;
    localparam logic [2:0] NB_DONE = 3'd5;

    typedef logic [NTHR-1:0][THR_W-1:0] thr_tab_t;

    typedef struct packed {
        logic       accept;
        logic [2:0] rd_idx;
        logic       cap_en;
        logic [2:0] cap_idx;
        logic       eval;
        logic       commit;
    } imsf_cmd_t;

    typedef struct packed {
        logic out_free;
    } imsf_sts_t;

endpackage

// File: rtl/core/imsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imsf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/imsf_ctrl.sv
// Sequencer: accept, fetch site and neighbors, evaluate, commit.
module imsf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  imsf_pkg::imsf_sts_t sts,
    output imsf_pkg::imsf_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FETCH  = 4'b0010,
        ST_EVAL   = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = imsf_pkg::NB_SITE;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.rd_idx  = cnt_reg;
                cmd.cap_en  = (cnt_reg != imsf_pkg::NB_SITE);
                cmd.cap_idx = cnt_reg - 3'd1;
                if (cnt_reg == imsf_pkg::NB_DONE)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: rtl/core/imsf_datapath.sv
// Lattice store, neighbor capture, energy/acceptance math, counters, output register.
module imsf_datapath #(
    parameter int SIDE = imsf_pkg::SIDE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  imsf_pkg::imsf_cmd_t           cmd,
    output imsf_pkg::imsf_sts_t           sts,
    input  logic [imsf_pkg::IN_W-1:0]     in_data,
    input  logic [imsf_pkg::FIELD_W-1:0]  field_strength,
    input  imsf_pkg::thr_tab_t            thr,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [imsf_pkg::OUT_W-1:0]    out_data
);

    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int LAST  = SIDE - 1;
    localparam int RCW   = imsf_pkg::RC_W;

    logic [1:0]                     op_reg;
    logic [RCW-1:0]                 row_reg, col_reg;
    logic                           spin_in_reg, field_in_reg;
    logic [imsf_pkg::RND_W-1:0]     rnd_reg;
    logic [1:0]                     site_reg;
    logic [3:0]                     nb_reg;
    logic                           acc_reg, spin_new_reg;
    logic signed [imsf_pkg::DE_W-1:0] de_reg;
    logic [imsf_pkg::CNT_W-1:0]     flip_reg, rej_reg, flip_next, rej_next;
    logic                           out_valid_reg;
    logic [imsf_pkg::OUT_W-1:0]     out_data_reg;

    logic [AW-1:0]  site_addr, raddr, waddr;
    logic [1:0]     rdata, wdata;
    logic           we;
    logic           in_range, is_att, is_load;
    logic           v_up, v_dn, v_lf, v_rt;
    logic signed [3:0] t_up, t_dn, t_lf, t_rt, nsum, k;
    logic [3:0]     kp;
    logic           se;
    logic [imsf_pkg::THR_IW-1:0] tidx;
    logic [imsf_pkg::THR_W-1:0]  thr_sel;
    logic signed [imsf_pkg::DE_W-1:0] k_term, h_term, half_de;
    logic           acc_c, spin_new_c;

    assign in_range = (row_reg < SIDE) && (col_reg < SIDE);
    assign is_att   = (op_reg == imsf_pkg::OP_ATTEMPT);
    assign is_load  = (op_reg == imsf_pkg::OP_LOAD);

    assign site_addr = AW'(AW'(row_reg) * AW'(SIDE)) + AW'(col_reg);

    always_comb
    begin
        case (cmd.rd_idx)
            imsf_pkg::NB_UP: raddr = site_addr - AW'(SIDE);
            imsf_pkg::NB_DN: raddr = site_addr + AW'(SIDE);
            imsf_pkg::NB_LF: raddr = site_addr - AW'(1);
            imsf_pkg::NB_RT: raddr = site_addr + AW'(1);
            default:         raddr = site_addr;
        endcase
    end

    // bit 1 field sign, bit 0 spin
    imsf_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_lattice (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign waddr = site_addr;
    assign we    = cmd.commit && in_range && (is_load || (is_att && acc_reg));
    assign wdata = is_load ? {field_in_reg, spin_in_reg} : {site_reg[1], ~site_reg[0]};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= in_data[1:0];
            row_reg      <= in_data[7:2];
            col_reg      <= in_data[13:8];
            spin_in_reg  <= in_data[14];
            field_in_reg <= in_data[15];
            rnd_reg      <= in_data[31:16];
        end
        if (cmd.cap_en)
        begin
            case (cmd.cap_idx)
                imsf_pkg::NB_SITE: site_reg  <= rdata;
                imsf_pkg::NB_UP:   nb_reg[0] <= rdata[0];
                imsf_pkg::NB_DN:   nb_reg[1] <= rdata[0];
                imsf_pkg::NB_LF:   nb_reg[2] <= rdata[0];
                imsf_pkg::NB_RT:   nb_reg[3] <= rdata[0];
                default:           ;
            endcase
        end
        if (cmd.eval)
        begin
            acc_reg      <= acc_c;
            spin_new_reg <= spin_new_c;
            de_reg       <= acc_c ? {half_de[imsf_pkg::DE_W-2:0], 1'b0} : '0;
        end
        if (cmd.commit)
        begin
            out_data_reg <= {7'd0, rej_next, flip_next, de_reg, acc_reg, spin_new_reg};
        end
    end

    // open boundary: missing neighbors count as zero
    assign v_up = (row_reg != '0);
    assign v_dn = (row_reg < LAST);
    assign v_lf = (col_reg != '0);
    assign v_rt = (col_reg < LAST);

    assign t_up = v_up ? (nb_reg[0] ? 4'sd1 : -4'sd1) : 4'sd0;
    assign t_dn = v_dn ? (nb_reg[1] ? 4'sd1 : -4'sd1) : 4'sd0;
    assign t_lf = v_lf ? (nb_reg[2] ? 4'sd1 : -4'sd1) : 4'sd0;
    assign t_rt = v_rt ? (nb_reg[3] ? 4'sd1 : -4'sd1) : 4'sd0;
    assign nsum = t_up + t_dn + t_lf + t_rt;
    assign k    = site_reg[0] ? nsum : -nsum;
    assign se   = ~(site_reg[0] ^ site_reg[1]);
    assign kp   = 4'(k + 4'sd4);
    assign tidx = {kp, se};
    assign thr_sel = thr[tidx];

    assign k_term  = imsf_pkg::DE_W'({{3{k[3]}}, k, 8'd0});
    assign h_term  = se ? imsf_pkg::DE_W'({3'd0, field_strength})
                        : -imsf_pkg::DE_W'({3'd0, field_strength});
    assign half_de = k_term + h_term;

    assign acc_c = is_att && in_range && (rnd_reg <= thr_sel);

    always_comb
    begin
        if (!in_range)
        begin
            spin_new_c = 1'b0;
        end
        else if (is_load)
        begin
            spin_new_c = spin_in_reg;
        end
        else
        begin
            spin_new_c = site_reg[0] ^ acc_c;
        end
    end

    always_comb
    begin
        flip_next = flip_reg;
        rej_next  = rej_reg;
        if (is_att && in_range)
        begin
            if (acc_reg)
            begin
                flip_next = (&flip_reg) ? flip_reg : flip_reg + 32'd1;
            end
            else
            begin
                rej_next = (&rej_reg) ? rej_reg : rej_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg      <= '0;
            rej_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                flip_reg      <= flip_next;
                rej_reg       <= rej_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

endmodule

// File: rtl/core/ising_metropolis_spin_flip.sv
// Top level: random-field Ising lattice with Metropolis single-spin-flip trials.
//
// Input words arrive on s_axis (operation, row, col, spin_value, field_positive,
// random_value). Load writes one site, attempt runs one trial at a site, read
// returns a site's spin. Each input word gives exactly one output word on
// m_axis (spin_now, accepted, energy_change, flip_total, reject_total).
// The user sets thresholds and field strength over the APB port only while
// idle; the block itself does not enforce this.
// A new input word is not taken until the last one has been written back; the
// lattice RAM has one read port, so the site and its four neighbors are fetched
// one per cycle, then the trial is evaluated, then the site is written back and
// the output register loaded.
// The next input word is taken while the output word waits; if the receiver
// stalls, the block holds in its commit step until the output register frees.
// Reset clears the counters, the output valid and the registers (field
// strength 256, thresholds 0). Lattice contents are undefined until loaded.
module ising_metropolis_spin_flip #(
    parameter int SIDE = imsf_pkg::SIDE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // operation[1:0], row[7:2], col[13:8], spin_value[14], field_positive[15],
    // random_value[31:16]
    input  logic [imsf_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // spin_now[0], accepted[1], energy_change[16:2], flip_total[48:17],
    // reject_total[80:49], zero[87:81]
    output logic [imsf_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [imsf_pkg::APB_AW-1:0]   paddr,
    input  logic [imsf_pkg::APB_DW-1:0]   pwdata,
    output logic [imsf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    logic [imsf_pkg::FIELD_W-1:0] field_reg;
    imsf_pkg::thr_tab_t           thr_reg;
    logic [2:0]                   reg_idx;
    logic                         wr;
    imsf_pkg::imsf_cmd_t          cmd;
    imsf_pkg::imsf_sts_t          sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg <= imsf_pkg::FIELD_RESET;
            thr_reg   <= '0;
        end
        else if (wr)
        begin
            case (reg_idx)
                imsf_pkg::REG_FIELD:
                begin
                    field_reg <= pwdata[11:0];
                end
                imsf_pkg::REG_THR_0_3, imsf_pkg::REG_THR_4_7,
                imsf_pkg::REG_THR_8_11, imsf_pkg::REG_THR_12_15:
                begin
                    for (int n = 0; n < 4; n++)
                    begin
                        thr_reg[(int'(reg_idx) - 1) * 4 + n] <= pwdata[16*n +: 16];
                    end
                end
                imsf_pkg::REG_THR_16_17:
                begin
                    thr_reg[16] <= pwdata[15:0];
                    thr_reg[17] <= pwdata[31:16];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            imsf_pkg::REG_FIELD:     prdata = {52'd0, field_reg};
            imsf_pkg::REG_THR_0_3:   prdata = {thr_reg[3], thr_reg[2], thr_reg[1], thr_reg[0]};
            imsf_pkg::REG_THR_4_7:   prdata = {thr_reg[7], thr_reg[6], thr_reg[5], thr_reg[4]};
            imsf_pkg::REG_THR_8_11:  prdata = {thr_reg[11], thr_reg[10], thr_reg[9], thr_reg[8]};
            imsf_pkg::REG_THR_12_15: prdata = {thr_reg[15], thr_reg[14], thr_reg[13],
                                               thr_reg[12]};
            imsf_pkg::REG_THR_16_17: prdata = {32'd0, thr_reg[17], thr_reg[16]};
            default:                 prdata = '0;
        endcase
    end

    imsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    imsf_datapath #(
        .SIDE (SIDE)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_data        (s_axis_tdata),
        .field_strength (field_reg),
        .thr            (thr_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_data       (m_axis_tdata)
    );

endmodule

// File: rtl/core/imsf_checker.sv
// Port-level checker for the spin-flip block, bound to the top level.
module imsf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [imsf_pkg::OUT_W-1:0] m_axis_tdata
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // one word in process at a time: no back-to-back input acceptance
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // rejected or non-trial word carries zero energy change
    a_de_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[16:2] == 15'd0)
        else $error("energy change without accepted flip");

    // accepted flip implies a nonzero flip total
    a_flip_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[48:17] != 32'd0)
        else $error("accepted flip with zero flip total");

endmodule

bind ising_metropolis_spin_flip imsf_checker u_imsf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/ising_metropolis_spin_flip_test.sv
// Self-checking testbench for the random-field Ising spin-flip block over stream and APB ports.
`timescale 1ns / 100ps

module ising_metropolis_spin_flip_test;
    import imsf_pkg::*;

    localparam int SIDE = SIDE_DEF;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic        spin;
        logic        acc;
        logic [14:0] de;
        logic [31:0] flips;
        logic [31:0] rejects;
    } outcome_t;

    typedef struct {
        logic [1:0] op;
        int         r;
        int         c;
        bit         s;
        bit         f;
        int         rnd;
        bit         typed;
        outcome_t   want;
    } probe_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    // predictor state
    bit          spin_map    [0:SIDE*SIDE-1];
    bit          sign_map    [0:SIDE*SIDE-1];
    bit          written_map [0:SIDE*SIDE-1];
    logic [15:0] thr_tab     [0:NTHR-1];
    logic [11:0] field_h;
    logic [31:0] flips;
    logic [31:0] rejects;

    outcome_t trial_outcomes_q[$];
    probe_t   probe_rows[$];
    int       fails = 0;
    int       n_words = 0;
    int       n_trials = 0;
    int       n_flips = 0;
    int       n_settings = 0;
    bit       calm = 1'b0;
    int       win_r = 0;
    int       win_c = 0;

    ising_metropolis_spin_flip u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int lattice_spin(int r, int c);
        if (r < 0 || c < 0 || r >= SIDE || c >= SIDE)
            return 0;
        return spin_map[r*SIDE+c] ? 1 : -1;
    endfunction

    function automatic bit trial_ready(int r, int c);
        bit ok;
        ok = written_map[r*SIDE+c];
        if (r > 0)      ok &= written_map[(r-1)*SIDE+c];
        if (r < SIDE-1) ok &= written_map[(r+1)*SIDE+c];
        if (c > 0)      ok &= written_map[r*SIDE+c-1];
        if (c < SIDE-1) ok &= written_map[r*SIDE+c+1];
        return ok;
    endfunction

    function automatic outcome_t predict_site_update(logic [1:0] op, int r, int c,
                                                     bit s_in, bit f_in, logic [15:0] rnd);
        outcome_t o;
        int pos, s, e, nb, k, se, de, idx;
        o = '0;
        pos = r*SIDE + c;
        if (op == OP_LOAD)
        begin
            spin_map[pos] = s_in;
            sign_map[pos] = f_in;
            written_map[pos] = 1'b1;
        end
        else if (op == OP_ATTEMPT)
        begin
            s = spin_map[pos] ? 1 : -1;
            e = sign_map[pos] ? 1 : -1;
            nb = lattice_spin(r-1, c) + lattice_spin(r+1, c)
               + lattice_spin(r, c-1) + lattice_spin(r, c+1);
            k = s * nb;
            se = s * e;
            de = 2 * (k*256 + int'(field_h)*se);
            idx = (k+4)*2 + ((se > 0) ? 1 : 0);
            if (rnd <= thr_tab[idx])
            begin
                spin_map[pos] = ~spin_map[pos];
                o.acc = 1'b1;
                o.de = de[14:0];
                if (flips != 32'hFFFF_FFFF)
                    flips++;
            end
            else if (rejects != 32'hFFFF_FFFF)
                rejects++;
        end
        o.spin = spin_map[pos];
        o.flips = flips;
        o.rejects = rejects;
        return o;
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [63:0] data);
        int base, cnt;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx == REG_FIELD)
            field_h = data[11:0];
        else
        begin
            base = (int'(idx) - 1) * 4;
            cnt = (idx == REG_THR_16_17) ? 2 : 4;
            for (int n = 0; n < cnt; n++)
                thr_tab[base+n] = data[16*n +: 16];
        end
    endtask

    task automatic configure(int mode);
        logic [15:0] t [0:NTHR-1];
        logic [63:0] fw;
        case (mode)
            0:
            begin
                fw = 64'd0;
                for (int i = 0; i < NTHR; i++) t[i] = 16'hFFFF;
            end
            1:
            begin
                fw = '1;
                for (int i = 0; i < NTHR; i++) t[i] = 16'h0000;
            end
            default:
            begin
                fw = {$urandom, $urandom};
                for (int i = 0; i < NTHR; i++)
                    case ($urandom_range(0, 3))
                        0: t[i] = 16'h0000;
                        1: t[i] = 16'hFFFF;
                        default: t[i] = 16'($urandom);
                    endcase
            end
        endcase
        apb_write(REG_FIELD, fw);
        apb_write(REG_THR_0_3, {t[3], t[2], t[1], t[0]});
        apb_write(REG_THR_4_7, {t[7], t[6], t[5], t[4]});
        apb_write(REG_THR_8_11, {t[11], t[10], t[9], t[8]});
        apb_write(REG_THR_12_15, {t[15], t[14], t[13], t[12]});
        apb_write(REG_THR_16_17, {32'($urandom), t[17], t[16]});
        n_settings++;
    endtask

    // drive one word, then record what it should produce
    task automatic issue_word(logic [1:0] op, int r, int c, bit s, bit f, logic [15:0] rnd,
                              bit typed, outcome_t want);
        outcome_t o;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata = $urandom;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {rnd, f, s, 6'(c), 6'(r), op};
        do @(posedge clk); while (!s_axis_tready);
        o = predict_site_update(op, r, c, s, f, rnd);
        trial_outcomes_q.push_back(typed ? want : o);
        n_words++;
        if (op == OP_ATTEMPT)
            n_trials++;
        if (o.acc)
            n_flips++;
    endtask

    task automatic hold_off();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        hold_off();
        while (trial_outcomes_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic add_probe(logic [1:0] op, int r, int c, bit s, bit f, int rnd, bit typed,
                             bit w_spin, bit w_acc, int w_de, int w_fl, int w_rj);
        probe_t p;
        p.op = op;
        p.r = r;
        p.c = c;
        p.s = s;
        p.f = f;
        p.rnd = rnd;
        p.typed = typed;
        p.want.spin = w_spin;
        p.want.acc = w_acc;
        p.want.de = w_de[14:0];
        p.want.flips = w_fl;
        p.want.rejects = w_rj;
        probe_rows.push_back(p);
    endtask

    task automatic run_random(int count);
        logic [1:0] op;
        logic [15:0] rnd;
        int r, c, roll;
        bit s, f;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                r = win_r + $urandom_range(0, 7);
                c = win_c + $urandom_range(0, 7);
            end
            else
            begin
                r = $urandom_range(0, SIDE-1);
                c = $urandom_range(0, SIDE-1);
            end
            roll = $urandom_range(0, 99);
            if (roll < 22)
                op = OP_LOAD;
            else if (roll < 82)
                op = OP_ATTEMPT;
            else if (roll < 94)
                op = OP_READ;
            else
                op = OP_SPARE;
            // never try or read a site that holds nothing yet, nor try one whose neighbor does
            if (op == OP_ATTEMPT && !trial_ready(r, c))
                op = OP_LOAD;
            if ((op == OP_READ || op == OP_SPARE) && !written_map[r*SIDE+c])
                op = OP_LOAD;
            s = $urandom_range(0, 1);
            f = $urandom_range(0, 1);
            roll = $urandom_range(0, 99);
            if (roll < 15)
                rnd = 16'h0000;
            else if (roll < 30)
                rnd = 16'hFFFF;
            else if (roll < 50)
                rnd = thr_tab[$urandom_range(0, NTHR-1)] + 16'($urandom_range(0, 2)) - 16'd1;
            else
                rnd = 16'($urandom);
            issue_word(op, r, c, s, f, rnd, 1'b0, '0);
        end
    endtask

    task automatic report_field(string name, logic [31:0] w, logic [31:0] g);
        if (w !== g)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, w, g);
            fails++;
        end
    endtask

    task automatic check_word(logic [OUT_W-1:0] d);
        outcome_t got, want;
        got.spin = d[0];
        got.acc = d[1];
        got.de = d[16:2];
        got.flips = d[48:17];
        got.rejects = d[80:49];
        if (trial_outcomes_q.size() == 0)
        begin
            $display("%0t: result word with none expected: %h", $time, d);
            fails++;
        end
        else
        begin
            want = trial_outcomes_q.pop_front();
            report_field("spin_now", want.spin, got.spin);
            report_field("accepted", want.acc, got.acc);
            report_field("energy_change", want.de, got.de);
            report_field("flip_total", want.flips, got.flips);
            report_field("reject_total", want.rejects, got.rejects);
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_axis_tready = calm || ($urandom_range(0, 99) >= 31);
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                check_word(m_axis_tdata);
        end
    end

    initial
    begin
        field_h = FIELD_RESET;
        flips = '0;
        rejects = '0;
        for (int i = 0; i < NTHR; i++)
            thr_tab[i] = '0;
        for (int i = 0; i < SIDE*SIDE; i++)
        begin
            spin_map[i] = 1'b0;
            sign_map[i] = 1'b0;
            written_map[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corners first, reset settings: field 256, all thresholds 0
        add_probe(OP_LOAD,     0,  0, 1, 1, 16'h0000, 1, 1, 0,    0, 0, 0);
        add_probe(OP_LOAD,     0,  1, 0, 0, 16'hFFFF, 1, 0, 0,    0, 0, 0);
        add_probe(OP_LOAD,     1,  0, 1, 1, 16'h8000, 1, 1, 0,    0, 0, 0);
        add_probe(OP_ATTEMPT,  0,  0, 0, 0, 16'h0000, 1, 0, 1,  512, 1, 0);
        add_probe(OP_ATTEMPT,  0,  0, 1, 1, 16'hFFFF, 1, 0, 0,    0, 1, 1);
        add_probe(OP_READ,     0,  0, 0, 0, 16'h1234, 1, 0, 0,    0, 1, 1);
        add_probe(OP_SPARE,    0,  1, 1, 1, 16'hFFFF, 1, 0, 0,    0, 1, 1);
        add_probe(OP_LOAD,    63, 63, 1, 0, 16'h0001, 1, 1, 0,    0, 1, 1);
        add_probe(OP_LOAD,    62, 63, 1, 1, 16'h5555, 1, 1, 0,    0, 1, 1);
        add_probe(OP_LOAD,    63, 62, 0, 1, 16'hAAAA, 1, 0, 0,    0, 1, 1);
        add_probe(OP_ATTEMPT, 63, 63, 0, 0, 16'hFFFF, 1, 1, 0,    0, 1, 2);
        add_probe(OP_ATTEMPT, 63, 63, 0, 0, 16'h0000, 1, 0, 1, -512, 2, 2);
        add_probe(OP_LOAD,    63,  0, 1, 0, 16'h7FFF, 1, 1, 0,    0, 2, 2);
        add_probe(OP_LOAD,    62,  0, 0, 1, 16'h0000, 1, 0, 0,    0, 2, 2);
        add_probe(OP_LOAD,    63,  1, 1, 1, 16'hFFFF, 1, 1, 0,    0, 2, 2);
        add_probe(OP_LOAD,     0, 63, 0, 0, 16'h0F0F, 1, 0, 0,    0, 2, 2);
        add_probe(OP_LOAD,     1, 63, 1, 0, 16'hF0F0, 1, 1, 0,    0, 2, 2);
        add_probe(OP_LOAD,     0, 62, 1, 1, 16'h0000, 1, 1, 0,    0, 2, 2);
        add_probe(OP_ATTEMPT,  0, 63, 0, 0, 16'h0000, 0, 0, 0,    0, 0, 0);
        add_probe(OP_ATTEMPT, 63,  0, 0, 0, 16'h0001, 0, 0, 0,    0, 0, 0);
        add_probe(OP_READ,    63, 63, 1, 1, 16'hFFFF, 0, 0, 0,    0, 0, 0);
        foreach (probe_rows[i])
            issue_word(probe_rows[i].op, probe_rows[i].r, probe_rows[i].c, probe_rows[i].s,
                       probe_rows[i].f, probe_rows[i].rnd[15:0], probe_rows[i].typed,
                       probe_rows[i].want);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            configure(ph);
            calm = (ph == 3);
            case (ph % 4)
                0:
                begin
                    win_r = 0;
                    win_c = 0;
                end
                1:
                begin
                    win_r = SIDE - 8;
                    win_c = SIDE - 8;
                end
                default:
                begin
                    win_r = $urandom_range(0, SIDE-8);
                    win_c = $urandom_range(0, SIDE-8);
                end
            endcase
            if (ph == 4)
            begin
                run_random(100);
                drain();
                run_random(129);
            end
            else
                run_random(229);
        end
        calm = 1'b0;

        hold_off();
        while (trial_outcomes_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Ran %0d words, %0d flip trials with %0d accepted, under %0d register settings",
                 n_words, n_trials, n_flips, n_settings);
        $display("including corner and edge sites, saturated thresholds and both field extremes");
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
